FILE: rtl/core/rpa_pkg.sv
// Shared types, constants and helpers for the refcounted page allocator.
package rpa_pkg;

   // Pool geometry and count width
   localparam int NUM_PAGES  = 65536;
   localparam int COUNT_BITS = 16;
   localparam int PAGE_BITS  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

   // Fixed field widths
   localparam int PAGE_W   = 16;
   localparam int CNT_W    = 16;
   localparam int FREE_W   = 17;
   localparam int LINK_W   = PAGE_W + 1;
   localparam int REQ_W    = 3;
   localparam int STATUS_W = 2;

   localparam logic [FREE_W-1:0]     FREE_MAX  = FREE_W'(NUM_PAGES);
   localparam logic [LINK_W-1:0]     END_MARK  = {1'b1, {PAGE_W{1'b0}}};
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [PAGE_BITS-1:0]  LAST_IDX  = PAGE_BITS'(NUM_PAGES - 1);

   // Request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_ALLOC = 3'd0,
      REQ_FREE  = 3'd1,
      REQ_INC   = 3'd2,
      REQ_DEC   = 3'd3,
      REQ_READ  = 3'd4
   } req_code_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_NO_FREE = 2'd1,
      ST_BAD     = 2'd2,
      ST_SAT     = 2'd3
   } status_type;

   // Controller states
   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   // Clamp a stored count to the reported width
   function automatic logic [CNT_W-1:0] sat_count(input logic [COUNT_BITS-1:0] c);
      logic [31:0] w;
      w = 32'(c);
      return (w > 32'h0000_FFFF) ? {CNT_W{1'b1}} : w[CNT_W-1:0];
   endfunction

endpackage

FILE: rtl/core/rpa_ifs.sv
// Request and response channel interfaces for the page allocator.
interface rpa_req_if;
   logic                        valid;
   logic                        ready;
   logic [rpa_pkg::REQ_W-1:0]   req_type;
   logic [rpa_pkg::PAGE_W-1:0]  page_number;

   modport source (output valid, req_type, page_number, input ready);
   modport sink   (input valid, req_type, page_number, output ready);
endinterface

interface rpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rpa_pkg::PAGE_W-1:0]    page_out;
   logic [rpa_pkg::CNT_W-1:0]     ref_count;
   logic [rpa_pkg::FREE_W-1:0]    pages_left;
   logic [rpa_pkg::STATUS_W-1:0]  status;

   modport source (output valid, page_out, ref_count, pages_left, status, input ready);
   modport sink   (input valid, page_out, ref_count, pages_left, status, output ready);
endinterface

FILE: rtl/core/refcounted_page_allocator.sv
// Page allocator top level: LIFO free list and per-page reference counts.
// A request is accepted in S_IDLE and executed in S_EXEC, which waits while an earlier
// response is unacknowledged; the response register is loaded as S_EXEC completes.
// No new request is taken until then: count and link memories are read at accept
// and written back in S_EXEC. Reset: a clearing pass zeroes NUM_PAGES (65536) count
// entries, one per cycle, during which no request is accepted; csr writes are taken.
module refcounted_page_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [rpa_pkg::PAGE_W-1:0]  csr_wdata,
   rpa_req_if.sink                     req_ch,
   rpa_rsp_if.source                   rsp_ch
);

   // Memories: counts (cleared by sweep) and list links (never cleared)
   logic [rpa_pkg::COUNT_BITS-1:0] refs_mem [rpa_pkg::NUM_PAGES];
   logic [rpa_pkg::LINK_W-1:0]     link_mem [rpa_pkg::NUM_PAGES];

   // Control and list state
   rpa_pkg::state_type             state_ff, state_in;
   logic [rpa_pkg::PAGE_BITS-1:0]  clr_addr_ff, clr_addr_in;
   logic [rpa_pkg::PAGE_W-1:0]     first_page_ff;
   logic [rpa_pkg::PAGE_W-1:0]     list_head_ff, list_head_in;
   logic                           list_empty_ff, list_empty_in;
   logic [rpa_pkg::FREE_W-1:0]     free_total_ff, free_total_in;

   // Captured request and memory read data
   logic [rpa_pkg::REQ_W-1:0]      req_type_ff;
   logic [rpa_pkg::PAGE_W-1:0]     page_ff;
   logic [rpa_pkg::COUNT_BITS-1:0] refs_rdata_ff;
   logic [rpa_pkg::LINK_W-1:0]     link_rdata_ff;

   // Response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [rpa_pkg::PAGE_W-1:0]     rsp_page_ff, rsp_page_in;
   logic [rpa_pkg::CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [rpa_pkg::FREE_W-1:0]     rsp_free_ff;
   logic [rpa_pkg::STATUS_W-1:0]   rsp_status_ff;
   rpa_pkg::status_type            rsp_status_in;

   // Memory write controls
   logic                           refs_we;
   logic [rpa_pkg::PAGE_BITS-1:0]  refs_waddr;
   logic [rpa_pkg::COUNT_BITS-1:0] refs_wdata;
   logic                           link_we;
   logic [rpa_pkg::PAGE_BITS-1:0]  link_waddr;
   logic [rpa_pkg::LINK_W-1:0]     link_wdata;

   logic                           req_fire;
   logic                           exec_fire;
   logic                           slot_free;

   assign req_ch.ready = (state_ff == rpa_pkg::S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign exec_fire    = (state_ff == rpa_pkg::S_EXEC) && slot_free;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.page_out   = rsp_page_ff;
   assign rsp_ch.ref_count  = rsp_count_ff;
   assign rsp_ch.pages_left = rsp_free_ff;
   assign rsp_ch.status     = rsp_status_ff;

   // State register and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rpa_pkg::S_CLEAR;
         clr_addr_ff   <= '0;
         first_page_ff <= '0;
         list_head_ff  <= '0;
         list_empty_ff <= 1'b1;
         free_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         list_head_ff  <= list_head_in;
         list_empty_ff <= list_empty_in;
         free_total_ff <= free_total_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            first_page_ff <= csr_wdata;
         end
      end
   end

   // Request capture and response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_type_ff <= req_ch.req_type;
         page_ff     <= req_ch.page_number;
      end
      if (exec_fire) begin
         rsp_page_ff   <= rsp_page_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_free_ff   <= free_total_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // Count memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (refs_we) begin
         refs_mem[refs_waddr] <= refs_wdata;
      end
      if (req_fire) begin
         refs_rdata_ff <= refs_mem[req_ch.page_number[rpa_pkg::PAGE_BITS-1:0]];
      end
   end

   // Link memory: read at the list head, written on push
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (req_fire) begin
         link_rdata_ff <= link_mem[list_head_ff[rpa_pkg::PAGE_BITS-1:0]];
      end
   end

   // Next state, request execution and memory writes
   always_comb begin
      logic                           bad_page;
      logic [rpa_pkg::COUNT_BITS-1:0] cnt;
      rpa_pkg::req_code_type          code;

      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      list_head_in  = list_head_ff;
      list_empty_in = list_empty_ff;
      free_total_in = free_total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_page_in   = page_ff;
      rsp_count_in  = '0;
      rsp_status_in = rpa_pkg::ST_OK;
      refs_we       = 1'b0;
      refs_waddr    = page_ff[rpa_pkg::PAGE_BITS-1:0];
      refs_wdata    = '0;
      link_we       = 1'b0;
      link_waddr    = page_ff[rpa_pkg::PAGE_BITS-1:0];
      link_wdata    = list_empty_ff ? rpa_pkg::END_MARK : {1'b0, list_head_ff};
      cnt           = refs_rdata_ff;
      code          = rpa_pkg::req_code_type'(req_type_ff);
      bad_page      = (page_ff < first_page_ff) ||
                      ({1'b0, page_ff} >= rpa_pkg::FREE_MAX);

      unique case (state_ff)
         rpa_pkg::S_CLEAR: begin
            // Sweep the count memory to zero
            refs_we     = 1'b1;
            refs_waddr  = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == rpa_pkg::LAST_IDX) begin
               state_in = rpa_pkg::S_IDLE;
            end
         end
         rpa_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = rpa_pkg::S_EXEC;
            end
         end
         rpa_pkg::S_EXEC: begin
            if (slot_free) begin
               state_in     = rpa_pkg::S_IDLE;
               rsp_valid_in = 1'b1;
               if (code == rpa_pkg::REQ_ALLOC) begin
                  // Pop the head page
                  if (list_empty_ff) begin
                     rsp_page_in   = '0;
                     rsp_status_in = rpa_pkg::ST_NO_FREE;
                  end else begin
                     rsp_page_in  = list_head_ff;
                     rsp_count_in = rpa_pkg::CNT_W'(1);
                     refs_we      = 1'b1;
                     refs_waddr   = list_head_ff[rpa_pkg::PAGE_BITS-1:0];
                     refs_wdata   = rpa_pkg::COUNT_BITS'(1);
                     if (link_rdata_ff[rpa_pkg::PAGE_W]) begin
                        list_empty_in = 1'b1;
                        list_head_in  = '0;
                     end else begin
                        list_head_in  = link_rdata_ff[rpa_pkg::PAGE_W-1:0];
                     end
                     if (free_total_ff != '0) begin
                        free_total_in = free_total_ff - 1'b1;
                     end
                  end
               end else if (bad_page) begin
                  rsp_status_in = rpa_pkg::ST_BAD;
               end else begin
                  // Count update; unused codes act as read
                  unique case (code)
                     rpa_pkg::REQ_FREE: begin
                        if (cnt <= rpa_pkg::COUNT_BITS'(1)) begin
                           cnt           = '0;
                           link_we       = 1'b1;
                           list_head_in  = page_ff;
                           list_empty_in = 1'b0;
                           if (free_total_ff < rpa_pkg::FREE_MAX) begin
                              free_total_in = free_total_ff + 1'b1;
                           end
                        end else begin
                           cnt = cnt - 1'b1;
                        end
                     end
                     rpa_pkg::REQ_INC: begin
                        if (cnt == rpa_pkg::COUNT_MAX) begin
                           rsp_status_in = rpa_pkg::ST_SAT;
                        end else begin
                           cnt = cnt + 1'b1;
                        end
                     end
                     rpa_pkg::REQ_DEC: begin
                        if (cnt == '0) begin
                           rsp_status_in = rpa_pkg::ST_SAT;
                        end else begin
                           cnt = cnt - 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
                  refs_we      = 1'b1;
                  refs_wdata   = cnt;
                  rsp_count_in = rpa_pkg::sat_count(cnt);
               end
            end
         end
         default: begin
            state_in = rpa_pkg::S_CLEAR;
         end
      endcase
   end

   // Checks
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_total_ff <= rpa_pkg::FREE_MAX)
      else $error("free page count above pool size");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      list_empty_ff |-> (list_head_ff == '0))
      else $error("empty list with nonzero head");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == rpa_pkg::S_EXEC) && !req_ch.ready)
      else $error("accepted request did not enter execution");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == rpa_pkg::S_EXEC))
      else $error("response raised outside execution");

endmodule
